>>> rtl/eopt_pkg.sv
`timescale 1ns / 1ps

package eopt_pkg;

  localparam int REG_BITS     = 10;
  localparam int CFG_IDX_BITS = 3;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_FOCUS_ONE_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOCUS_ONE_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOCUS_TWO_X    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOCUS_TWO_Y    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISTANCE_TOTAL = 3'd4;

  typedef struct packed {
    logic [REG_BITS-1:0] focus_one_x;
    logic [REG_BITS-1:0] focus_one_y;
    logic [REG_BITS-1:0] focus_two_x;
    logic [REG_BITS-1:0] focus_two_y;
    logic [REG_BITS-1:0] distance_total;
  } eopt_cfg_t;

  // control that rides along each pipeline stage
  typedef struct packed {
    logic valid;
    logic box;
  } eopt_ctl_t;

endpackage

>>> rtl/eopt_pix_if.sv
`timescale 1ns / 1ps

interface eopt_pix_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> rtl/eopt_res_if.sv
`timescale 1ns / 1ps

interface eopt_res_if ();
  logic valid;
  logic ready;
  logic on_curve;
  logic in_box;

  modport source (output valid, output on_curve, output in_box, input ready);
  modport sink (input valid, input on_curve, input in_box, output ready);
endinterface

>>> rtl/eopt_cfg_if.sv
`timescale 1ns / 1ps

interface eopt_cfg_if
  import eopt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/eopt_front.sv
`timescale 1ns / 1ps

module eopt_front
  import eopt_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int DW         = 13,
  parameter int AW         = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  input  eopt_cfg_t                    cfg,
  output eopt_ctl_t                    ctl_o,
  output logic [AW-1:0]                ax_o [2],
  output logic [AW-1:0]                ay_o [2]
);

  localparam int PAD = DW - REG_BITS;

  logic signed [DW-1:0] px, py, r;
  logic signed [DW-1:0] fx [2];
  logic signed [DW-1:0] fy [2];
  logic signed [DW-1:0] dx [2];
  logic signed [DW-1:0] dy [2];
  logic signed [DW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [REG_BITS-1:0]  min_x, max_x, min_y, max_y;
  logic [AW-1:0]        ax_nxt [2];
  logic [AW-1:0]        ay_nxt [2];
  logic                 box;
  eopt_ctl_t            ctl_r;
  logic [AW-1:0]        ax_r [2];
  logic [AW-1:0]        ay_r [2];

  assign px = DW'(pixel_x);
  assign py = DW'(pixel_y);
  assign r  = $signed({{PAD{1'b0}}, cfg.distance_total});

  assign fx[0] = $signed({{PAD{1'b0}}, cfg.focus_one_x});
  assign fy[0] = $signed({{PAD{1'b0}}, cfg.focus_one_y});
  assign fx[1] = $signed({{PAD{1'b0}}, cfg.focus_two_x});
  assign fy[1] = $signed({{PAD{1'b0}}, cfg.focus_two_y});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l]     = px - fx[l];
      dy[l]     = py - fy[l];
      ax_nxt[l] = dx[l][DW-1] ? AW'(-dx[l]) : AW'(dx[l]);
      ay_nxt[l] = dy[l][DW-1] ? AW'(-dy[l]) : AW'(dy[l]);
    end
  end

  // bounding box: foci extremes widened by the distance total
  always_comb begin
    min_x = (cfg.focus_one_x < cfg.focus_two_x) ? cfg.focus_one_x : cfg.focus_two_x;
    max_x = (cfg.focus_one_x > cfg.focus_two_x) ? cfg.focus_one_x : cfg.focus_two_x;
    min_y = (cfg.focus_one_y < cfg.focus_two_y) ? cfg.focus_one_y : cfg.focus_two_y;
    max_y = (cfg.focus_one_y > cfg.focus_two_y) ? cfg.focus_one_y : cfg.focus_two_y;
    lo_x  = $signed({{PAD{1'b0}}, min_x}) - r;
    hi_x  = $signed({{PAD{1'b0}}, max_x}) + r;
    lo_y  = $signed({{PAD{1'b0}}, min_y}) - r;
    hi_y  = $signed({{PAD{1'b0}}, max_y}) + r;
    box   = (px >= lo_x) && (px <= hi_x) && (py >= lo_y) && (py <= hi_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r.valid <= in_valid;
      ctl_r.box   <= box;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ax_r[l] <= ax_nxt[l];
        ay_r[l] <= ay_nxt[l];
      end
    end
  end

  assign ctl_o = ctl_r;
  assign ax_o  = ax_r;
  assign ay_o  = ay_r;

endmodule

>>> rtl/eopt_dist.sv
`timescale 1ns / 1ps

module eopt_dist
  import eopt_pkg::*;
#(
  parameter int AW        = 12,
  parameter int FRAC_BITS = 8,
  parameter int RAD_BITS  = 2 * AW + 2 + 2 * FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  eopt_ctl_t           ctl_i,
  input  logic [AW-1:0]       ax_i [2],
  input  logic [AW-1:0]       ay_i [2],
  output eopt_ctl_t           ctl_o,
  output logic [RAD_BITS-1:0] rad_o [2]
);

  localparam int SQW = 2 * AW + 1;
  localparam int TOP = RAD_BITS - SQW - 2 * FRAC_BITS;

  eopt_ctl_t           sq_ctl_r, rad_ctl_r;
  logic [2*AW-1:0]     sqx_r [2];
  logic [2*AW-1:0]     sqy_r [2];
  logic [SQW-1:0]      sum [2];
  logic [RAD_BITS-1:0] rad_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r  <= '0;
      rad_ctl_r <= '0;
    end else if (en) begin
      sq_ctl_r  <= ctl_i;
      rad_ctl_r <= sq_ctl_r;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = SQW'(sqx_r[l]) + SQW'(sqy_r[l]);
    end
  end

  // squares first, then their sum scaled for the fraction bits of the root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        sqx_r[l] <= ax_i[l] * ax_i[l];
        sqy_r[l] <= ay_i[l] * ay_i[l];
        rad_r[l] <= {{TOP{1'b0}}, sum[l], {(2 * FRAC_BITS){1'b0}}};
      end
    end
  end

  assign ctl_o = rad_ctl_r;
  assign rad_o = rad_r;

endmodule

>>> rtl/eopt_isqrt.sv
`timescale 1ns / 1ps

module eopt_isqrt
  import eopt_pkg::*;
#(
  parameter int RAD_BITS = 42,
  parameter int RB       = RAD_BITS / 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  eopt_ctl_t           ctl_i,
  input  logic [RAD_BITS-1:0] rad_i [2],
  output eopt_ctl_t           ctl_o,
  output logic [RB-1:0]       root_o [2]
);

  // one root bit per stage, both foci side by side
  eopt_ctl_t           ctl_r  [RB];
  logic [RB-1:0]       root_r [RB][2];
  logic [RB-1:0]       rem_r  [RB-1][2];
  logic [RAD_BITS-1:0] rad_r  [RB-1][2];

  for (genvar s = 0; s < RB; s++) begin : g_stage
    eopt_ctl_t ctl_in;

    if (s == 0) begin : g_first
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign ctl_in = ctl_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (en) begin
        ctl_r[s] <= ctl_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RB-1:0]       rem_in, root_in, root_nxt, rem_nxt;
      logic [RAD_BITS-1:0] rad_in;
      logic [RB+1:0]       rem_n, trial, diff;
      logic                ge;

      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad_i[l];
      end else begin : g_next
        assign rem_in  = rem_r[s-1][l];
        assign root_in = root_r[s-1][l];
        assign rad_in  = rad_r[s-1][l];
      end

      always_comb begin
        rem_n    = {rem_in, rad_in[2 * (RB - 1 - s) + 1 -: 2]};
        trial    = {root_in, 2'b01};
        diff     = rem_n - trial;
        ge       = (rem_n >= trial);
        root_nxt = {root_in[RB-2:0], ge};
        rem_nxt  = ge ? diff[RB-1:0] : rem_n[RB-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[s][l] <= root_nxt;
        end
      end

      if (s < RB - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s][l] <= rem_nxt;
            rad_r[s][l] <= rad_in;
          end
        end
      end
    end
  end

  assign ctl_o     = ctl_r[RB-1];
  assign root_o[0] = root_r[RB-1][0];
  assign root_o[1] = root_r[RB-1][1];

endmodule

>>> rtl/ellipse_outline_pixel_test_unit.sv
`timescale 1ns / 1ps
// Ellipse outline pixel test.
// Channels: in_pix carries one pixel (pixel_x, pixel_y, two's complement) per beat;
// out_res returns one beat per pixel, in order: on_curve and in_box. cfg_wr writes
// a register by index (0 focus_one_x, 1 focus_one_y, 2 focus_two_x, 3 focus_two_y,
// 4 distance_total); other indexes are dropped. cfg_wr is always ready; write it
// only while no pixel is in flight.
// Stages: each pixel passes the front register, the squares and sum registers in
// eopt_dist, the root stages and the output register. The focal roots take one
// bit per stage, which sets the pipeline depth.
// Throughput: one pixel per cycle. A new pixel is taken while a result waits at
// the output, as long as the last root stage is empty; once it holds an item
// too, the whole pipeline holds until out_res is taken, losing nothing.
// Reset: synchronous rst_n zeroes the cfg and valid bits, emptying the pipeline.

module ellipse_outline_pixel_test_unit
  import eopt_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  eopt_pix_if.sink     in_pix,
  eopt_res_if.source   out_res,
  eopt_cfg_if.sink     cfg_wr
);

  localparam int DW       = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS + 1) + 1;
  localparam int AW       = DW - 1;
  localparam int RB       = AW + 1 + FRAC_BITS;
  localparam int RAD_BITS = 2 * RB;
  localparam int SW       = RB + 1;
  localparam int EW       = SW + 1;
  localparam int TOL      = (4 << FRAC_BITS) / 5;

  eopt_cfg_t       cfg_r, cfg_nxt;
  eopt_ctl_t       front_ctl, dist_ctl, root_ctl;
  logic [AW-1:0]   ax [2];
  logic [AW-1:0]   ay [2];
  logic [RAD_BITS-1:0] rad [2];
  logic [RB-1:0]   root [2];
  logic            en, out_load;
  logic            out_valid_r, on_curve_r, in_box_r;
  logic [SW-1:0]   dsum;
  logic [EW-1:0]   tgt;
  logic            on_nxt;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_FOCUS_ONE_X:    cfg_nxt.focus_one_x    = cfg_wr.data;
        REG_FOCUS_ONE_Y:    cfg_nxt.focus_one_y    = cfg_wr.data;
        REG_FOCUS_TWO_X:    cfg_nxt.focus_two_x    = cfg_wr.data;
        REG_FOCUS_TWO_Y:    cfg_nxt.focus_two_y    = cfg_wr.data;
        REG_DISTANCE_TOTAL: cfg_nxt.distance_total = cfg_wr.data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_wr.ready = 1'b1;

  // pipeline advances unless the last root stage is full and blocked by the output
  assign out_load     = out_res.ready || !out_valid_r;
  assign en           = out_load || !root_ctl.valid;
  assign in_pix.ready = en;

  eopt_front #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW),
    .AW         (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_pix.valid),
    .pixel_x  (in_pix.pixel_x),
    .pixel_y  (in_pix.pixel_y),
    .cfg      (cfg_r),
    .ctl_o    (front_ctl),
    .ax_o     (ax),
    .ay_o     (ay)
  );

  eopt_dist #(
    .AW        (AW),
    .FRAC_BITS (FRAC_BITS),
    .RAD_BITS  (RAD_BITS)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (front_ctl),
    .ax_i  (ax),
    .ay_i  (ay),
    .ctl_o (dist_ctl),
    .rad_o (rad)
  );

  eopt_isqrt #(
    .RAD_BITS (RAD_BITS),
    .RB       (RB)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (dist_ctl),
    .rad_i  (rad),
    .ctl_o  (root_ctl),
    .root_o (root)
  );

  // |d1 + d2 - total| <= tol, written as two one-sided compares
  always_comb begin
    dsum   = SW'(root[0]) + SW'(root[1]);
    tgt    = EW'({cfg_r.distance_total, {FRAC_BITS{1'b0}}});
    on_nxt = (EW'(dsum) <= tgt + EW'(TOL)) && (EW'(dsum) + EW'(TOL) >= tgt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= root_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      on_curve_r <= on_nxt;
      in_box_r   <= root_ctl.box;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.on_curve = on_curve_r;
  assign out_res.in_box   = in_box_r;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> front_ctl.valid)
    else $error("accepted pixel did not enter the first stage");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    root_ctl.valid && out_valid_r && !out_res.ready |-> !en)
    else $error("pipeline advanced into a blocked output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !front_ctl.valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> test/ellipse_outline_pixel_test_unit_tb.sv
`timescale 1ns / 1ps

module ellipse_outline_pixel_test_unit_tb;
  import eopt_pkg::*;

  localparam int     PIX_BITS    = 12;
  localparam int     FRAC_BITS   = 8;
  localparam longint TOL         = (4 << FRAC_BITS) / 5;
  localparam int     NUM_REGS    = 5;
  localparam longint REG_MAX     = (1 << REG_BITS) - 1;
  localparam int     PHASES      = 12;
  localparam int     PHASE_ITEMS = 150;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     REPORT_CAP  = 100;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   on_curve;
    logic   in_box;
  } verdict_t;

  logic clk;
  logic rst_n;

  eopt_pix_if #(.COORD_BITS(PIX_BITS)) pix_if ();
  eopt_res_if res_if ();
  eopt_cfg_if cfg_if ();

  ellipse_outline_pixel_test_unit #(
    .COORD_BITS(PIX_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  eopt_cfg_t shape;
  pixel_t    pending_pixels[$];
  verdict_t  pending_verdicts[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  logic      pix_beat = 1'b0;
  logic      steady_flow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, probe;
    rem = v;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // distance to one focus, scaled by 2^FRAC_BITS and truncated
  function automatic longint unsigned focal_root(longint px, longint py,
                                                 logic [REG_BITS-1:0] fx,
                                                 logic [REG_BITS-1:0] fy);
    longint dx, dy;
    dx = px - longint'(fx);
    dy = py - longint'(fy);
    return int_sqrt(longint'(dx * dx + dy * dy) << (2 * FRAC_BITS));
  endfunction

  function automatic longint focal_sum(longint px, longint py);
    return longint'(focal_root(px, py, shape.focus_one_x, shape.focus_one_y) +
                    focal_root(px, py, shape.focus_two_x, shape.focus_two_y));
  endfunction

  // box edges along one axis, margin included
  function automatic longint span_lo(bit y_axis);
    longint a, b;
    a = y_axis ? shape.focus_one_y : shape.focus_one_x;
    b = y_axis ? shape.focus_two_y : shape.focus_two_x;
    return ((a < b) ? a : b) - longint'(shape.distance_total);
  endfunction

  function automatic longint span_hi(bit y_axis);
    longint a, b;
    a = y_axis ? shape.focus_one_y : shape.focus_one_x;
    b = y_axis ? shape.focus_two_y : shape.focus_two_x;
    return ((a > b) ? a : b) + longint'(shape.distance_total);
  endfunction

  function automatic verdict_t predict_verdict(pixel_t p);
    longint   px, py, diff;
    verdict_t v;
    px = $signed(p.x);
    py = $signed(p.y);
    diff = focal_sum(px, py) - (longint'(shape.distance_total) << FRAC_BITS);
    v.pix = p;
    v.on_curve = ((diff < 0) ? -diff : diff) <= TOL;
    v.in_box = px >= span_lo(0) && px <= span_hi(0) && py >= span_lo(1) && py <= span_hi(1);
    return v;
  endfunction

  // pick a coordinate on one axis, then binary search the other axis outward from
  // the foci for the first point whose distance sum reaches the total
  function automatic pixel_t near_outline();
    bit     along_x, upward;
    longint r, target, a, lo, hi, mid, f_lo, f_hi;
    pixel_t p;
    along_x = 1'($urandom_range(0, 1));
    upward = 1'($urandom_range(0, 1));
    r = shape.distance_total;
    target = r << FRAC_BITS;
    a = span_lo(along_x) + longint'($urandom_range(0, span_hi(along_x) - span_lo(along_x)));
    f_lo = span_lo(!along_x) + r;
    f_hi = span_hi(!along_x) - r;
    if (upward) begin
      lo = f_hi;
      hi = f_hi + r;
      while (lo < hi) begin
        mid = (lo + hi) >>> 1;
        if (focal_sum(along_x ? mid : a, along_x ? a : mid) >= target) hi = mid;
        else lo = mid + 1;
      end
    end else begin
      lo = f_lo - r;
      hi = f_lo;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 1) >>> 1);
        if (focal_sum(along_x ? mid : a, along_x ? a : mid) >= target) lo = mid;
        else hi = mid - 1;
      end
    end
    lo += longint'($urandom_range(0, 2)) - 1;
    p.x = along_x ? lo[PIX_BITS-1:0] : a[PIX_BITS-1:0];
    p.y = along_x ? a[PIX_BITS-1:0] : lo[PIX_BITS-1:0];
    return p;
  endfunction

  function automatic longint edge_coord(bit y_axis);
    case ($urandom_range(0, 4))
      0: return span_lo(y_axis) - 1;
      1: return span_lo(y_axis);
      2: return span_hi(y_axis);
      3: return span_hi(y_axis) + 1;
      default: return span_lo(y_axis) +
                      longint'($urandom_range(0, span_hi(y_axis) - span_lo(y_axis)));
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return REG_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] clamp_reg(longint v);
    return (v < 0) ? '0 : (v > REG_MAX) ? '1 : v[REG_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    // keep the log short on a badly broken block
    if (mismatch_count <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = PIX_BITS'(x);
    p.y = PIX_BITS'(y);
    pending_pixels.push_back(p);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      REG_FOCUS_ONE_X:    shape.focus_one_x = val;
      REG_FOCUS_ONE_Y:    shape.focus_one_y = val;
      REG_FOCUS_TWO_X:    shape.focus_two_x = val;
      REG_FOCUS_TWO_Y:    shape.focus_two_y = val;
      REG_DISTANCE_TOTAL: shape.distance_total = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_junk_reg();
    write_reg(CFG_IDX_BITS'(REG_DISTANCE_TOTAL +
              $urandom_range(1, (1 << CFG_IDX_BITS) - 1 - REG_DISTANCE_TOTAL)),
              REG_BITS'($urandom));
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || pix_if.valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic shape_random();
    logic [REG_BITS-1:0] vals [NUM_REGS];
    longint              dx, dy, span;
    int                  start;
    vals[REG_FOCUS_ONE_X] = pick_coord();
    vals[REG_FOCUS_ONE_Y] = pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        // coincident foci, outline is a circle
        vals[REG_FOCUS_TWO_X] = vals[REG_FOCUS_ONE_X];
        vals[REG_FOCUS_TWO_Y] = vals[REG_FOCUS_ONE_Y];
      end
      1: begin
        vals[REG_FOCUS_TWO_X] = pick_coord();
        vals[REG_FOCUS_TWO_Y] = pick_coord();
      end
      default: begin
        vals[REG_FOCUS_TWO_X] = clamp_reg(longint'(vals[REG_FOCUS_ONE_X]) +
                                          longint'($urandom_range(0, 400)) - 200);
        vals[REG_FOCUS_TWO_Y] = clamp_reg(longint'(vals[REG_FOCUS_ONE_Y]) +
                                          longint'($urandom_range(0, 400)) - 200);
      end
    endcase
    dx = longint'(vals[REG_FOCUS_TWO_X]) - longint'(vals[REG_FOCUS_ONE_X]);
    dy = longint'(vals[REG_FOCUS_TWO_Y]) - longint'(vals[REG_FOCUS_ONE_Y]);
    span = longint'(int_sqrt(dx * dx + dy * dy)) + 1;
    case ($urandom_range(0, 9))
      0: vals[REG_DISTANCE_TOTAL] = '0;
      1: vals[REG_DISTANCE_TOTAL] = '1;
      2: vals[REG_DISTANCE_TOTAL] = REG_BITS'($urandom);
      default: vals[REG_DISTANCE_TOTAL] = clamp_reg(span + longint'($urandom_range(0, 120)));
    endcase
    if ($urandom_range(0, 2) == 0) write_junk_reg();
    start = $urandom_range(0, NUM_REGS - 1);
    for (int k = 0; k < NUM_REGS; k++)
      write_reg(CFG_IDX_BITS'((start + k) % NUM_REGS), vals[(start + k) % NUM_REGS]);
  endtask

  task automatic queue_phase(int count);
    pixel_t p;
    int     roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        p = near_outline();
      end else if (roll < 80) begin
        p.x = PIX_BITS'(edge_coord(0));
        p.y = PIX_BITS'(edge_coord(1));
      end else begin
        p = (2 * PIX_BITS)'($urandom);
      end
      pending_pixels.push_back(p);
    end
  endtask

  // driver: pixel beats and result back-pressure, changed on the falling edge
  always @(negedge clk) begin : pix_driver
    pixel_t nxt;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady_flow || ($urandom_range(0, 99) >= 20);
      if (!pix_if.valid || pix_beat) begin
        if (pending_pixels.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 20)) begin
          nxt = pending_pixels.pop_front();
          pix_if.valid   <= 1'b1;
          pix_if.pixel_x <= nxt.x;
          pix_if.pixel_y <= nxt.y;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predicts on each accepted pixel, checks each accepted result
  always @(posedge clk) begin : res_monitor
    verdict_t want;
    pixel_t   got_pix;
    cycle_count++;
    if (!rst_n) begin
      pix_beat <= 1'b0;
    end else begin
      pix_beat <= pix_if.valid && pix_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result beat with no pixel pending: on_curve=%b in_box=%b",
                                    res_if.on_curve, res_if.in_box));
        end else begin
          want = pending_verdicts.pop_front();
          if (res_if.on_curve !== want.on_curve)
            report_mismatch($sformatf("pixel (%0d,%0d) on_curve got %b want %b",
                                      want.pix.x, want.pix.y, res_if.on_curve, want.on_curve));
          if (res_if.in_box !== want.in_box)
            report_mismatch($sformatf("pixel (%0d,%0d) in_box got %b want %b",
                                      want.pix.x, want.pix.y, res_if.in_box, want.in_box));
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        got_pix.x = pix_if.pixel_x;
        got_pix.y = pix_if.pixel_y;
        pending_verdicts.push_back(predict_verdict(got_pix));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pix_if.valid   = 1'b0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    shape          = '0;
    rst_n          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: zero total, both foci at the origin
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(-1, -1);
    queue_pixel(-2048, -2048);
    queue_pixel(2047, 2047);
    queue_pixel(-2048, 2047);
    queue_pixel(2047, -2048);
    drain();

    // coincident foci: circle of radius 20
    write_reg(REG_FOCUS_ONE_X, 10'd100);
    write_reg(REG_FOCUS_ONE_Y, 10'd100);
    write_reg(REG_FOCUS_TWO_X, 10'd100);
    write_reg(REG_FOCUS_TWO_Y, 10'd100);
    write_reg(REG_DISTANCE_TOTAL, 10'd40);
    queue_pixel(120, 100);
    queue_pixel(100, 80);
    queue_pixel(114, 114);
    queue_pixel(100, 100);
    queue_pixel(140, 60);
    queue_pixel(141, 100);
    queue_pixel(100, 59);
    drain();

    // all registers at their maximum, unknown indexes mixed in
    write_junk_reg();
    write_reg(REG_FOCUS_ONE_X, '1);
    write_junk_reg();
    write_reg(REG_FOCUS_ONE_Y, '1);
    write_reg(REG_FOCUS_TWO_X, '1);
    write_reg(REG_FOCUS_TWO_Y, '1);
    write_reg(REG_DISTANCE_TOTAL, '1);
    write_junk_reg();
    queue_pixel(2046, 1023);
    queue_pixel(2047, 1023);
    queue_pixel(0, 0);
    queue_pixel(-1, 0);
    queue_pixel(1535, 1023);
    queue_pixel(1023, 1534);
    queue_pixel(1023, 1023);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      shape_random();
      steady_flow = (phase == 5);
      if (phase == 2) begin
        // sender holds off mid-phase until every result is back
        queue_phase(PHASE_ITEMS / 2);
        drain();
        queue_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_phase(PHASE_ITEMS);
      end
      drain();
    end
    steady_flow = 1'b0;

    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/eopt_pkg.sv
rtl/eopt_pix_if.sv
rtl/eopt_res_if.sv
rtl/eopt_cfg_if.sv
rtl/eopt_front.sv
rtl/eopt_dist.sv
rtl/eopt_isqrt.sv
rtl/ellipse_outline_pixel_test_unit.sv
test/ellipse_outline_pixel_test_unit_tb.sv
